// ===== rtl/pmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsf_pkg: shared types and constants of the pointer motion smoothing filter
// Beat layouts, configuration register map, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmsf_pkg;

  // Field widths of the beats and registers.
  localparam int DX_W        = 16;
  localparam int WGT_W       = 17;
  localparam int LIM_W       = 7;
  localparam int GAIN_W      = 16;
  localparam int AXIS_W      = 28;
  localparam int AVG_W       = 32;
  localparam int FRAC_SHIFT  = 16;
  localparam int SCALE_SHIFT = 20;

  // Unity weight in Q1.16.
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  // Register reset values.
  localparam logic              RST_SMOOTH = 1'b1;
  localparam logic [WGT_W-1:0]  RST_WEIGHT = 17'd39322;
  localparam logic [LIM_W-1:0]  RST_LIMIT  = 7'd32;
  localparam logic [GAIN_W-1:0] RST_YAW    = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_PITCH  = 16'd4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH = 3'd0,
    REG_WEIGHT = 3'd1,
    REG_LIMIT  = 3'd2,
    REG_YAW    = 3'd3,
    REG_PITCH  = 3'd4
  } pmsf_reg_idx_t;

  typedef struct packed {
    logic              smoothing_enable;
    logic [WGT_W-1:0]  decay_weight;
    logic [LIM_W-1:0]  sample_limit;
    logic [GAIN_W-1:0] yaw_gain;
    logic [GAIN_W-1:0] pitch_gain;
  } pmsf_cfg_t;

  // Input and result beats.
  typedef struct packed {
    logic signed [DX_W-1:0] delta_x;
    logic signed [DX_W-1:0] delta_y;
    logic                   clear_history;
  } pmsf_in_t;

  typedef struct packed {
    logic                     moved;
    logic                     send_event;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
  } pmsf_out_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WSTART,
    ST_WALK,
    ST_DSTART,
    ST_DIV,
    ST_AVG,
    ST_SCALE,
    ST_ROUND,
    ST_OUT
  } pmsf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk_start;
    logic div_start;
    logic div_step;
    logic avg_load;
    logic scale;
    logic round;
    logic out_load;
  } pmsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_moved;
    logic smooth;
    logic walk_done;
    logic div_done;
    logic out_free;
  } pmsf_stat_t;

endpackage

// ===== rtl/pmsf_cfg.sv =====
// ----------------------------------------------------------------------------
// pmsf_cfg: configuration register file
// Holds the five filter registers and takes one write beat per cycle.
// ----------------------------------------------------------------------------
module pmsf_cfg
  import pmsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pmsf_cfg_t             cfg
);

  pmsf_cfg_t cfg_r;
  pmsf_cfg_t cfg_nxt;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (pmsf_reg_idx_t'(cfg_index))
        REG_SMOOTH: cfg_nxt.smoothing_enable = cfg_data[0];
        REG_WEIGHT: cfg_nxt.decay_weight     = cfg_data[WGT_W-1:0];
        REG_LIMIT:  cfg_nxt.sample_limit     = cfg_data[LIM_W-1:0];
        REG_YAW:    cfg_nxt.yaw_gain         = cfg_data[GAIN_W-1:0];
        REG_PITCH:  cfg_nxt.pitch_gain       = cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_enable <= RST_SMOOTH;
      cfg_r.decay_weight     <= RST_WEIGHT;
      cfg_r.sample_limit     <= RST_LIMIT;
      cfg_r.yaw_gain         <= RST_YAW;
      cfg_r.pitch_gain       <= RST_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/pmsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmsf_ctrl: sequencing state machine
// Steps a beat through history walk and division (if smoothing), scaling and output.
// ----------------------------------------------------------------------------
module pmsf_ctrl
  import pmsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pmsf_stat_t st,
  output pmsf_cmd_t  cmd
);

  pmsf_state_t state_r;
  pmsf_state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!st.in_moved) begin
            state_nxt = ST_OUT;
          end else if (st.smooth) begin
            state_nxt = ST_WSTART;
          end else begin
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_WSTART: state_nxt = ST_WALK;
      ST_WALK: begin
        if (st.walk_done) begin
          state_nxt = ST_DSTART;
        end
      end
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (st.div_done) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT: begin
        if (st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: the input side is open only in the idle state.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_WSTART: cmd.walk_start = 1'b1;
      ST_WALK:   ;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_AVG:    cmd.avg_load = 1'b1;
      ST_SCALE:  cmd.scale = 1'b1;
      ST_ROUND:  cmd.round = 1'b1;
      ST_OUT:    cmd.out_load = st.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pmsf_dp.sv =====
// ----------------------------------------------------------------------------
// pmsf_dp: filter datapath
// History ring buffer, weighted sum pipeline, radix-4 divider, gain scaling
// with truncation and saturation, held axes and the result register.
// ----------------------------------------------------------------------------
module pmsf_dp
  import pmsf_pkg::*;
#(
  parameter int MAX_SAMPLE_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pmsf_cfg_t  cfg,
  input  pmsf_in_t   in_data,
  input  pmsf_cmd_t  cmd,
  output pmsf_stat_t st,
  input  logic       out_stall,
  output logic       out_valid,
  output pmsf_out_t  out_data
);

  localparam int DEPTH     = MAX_SAMPLE_LIMIT + 1;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int PRD_W     = DX_W + WGT_W;
  localparam int SUM_W     = PRD_W + CNT_W;
  localparam int DIV_W     = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int SC_W      = AVG_W + GAIN_W + 1;
  localparam int R_W       = SC_W - SCALE_SHIFT;

  localparam logic [PTR_W-1:0]        LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]        CNT_TOP  = CNT_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]        LIM_MAX  = CMP_W'(MAX_SAMPLE_LIMIT);
  localparam logic signed [R_W-1:0]   R_MAX    = R_W'((1 <<< (AXIS_W - 1)) - 1);
  localparam logic signed [R_W-1:0]   R_MIN    = R_W'(-(1 <<< (AXIS_W - 1)));

  // One restoring division step: shift in the next dividend bit.
  function automatic logic [CNT_W+DIV_W-1:0] div_step(
    input logic [CNT_W-1:0] rem,
    input logic [DIV_W-1:0] dq,
    input logic [CNT_W-1:0] dvs
  );
    logic [CNT_W:0]   t;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] rem_o;
    logic             qb;
    t     = {rem, dq[DIV_W-1]};
    diff  = t - {1'b0, dvs};
    qb    = (t >= {1'b0, dvs});
    rem_o = qb ? diff[CNT_W-1:0] : t[CNT_W-1:0];
    return {rem_o, dq[DIV_W-2:0], qb};
  endfunction

  // Divide by 2^20 truncating toward zero, then clamp to the axis range.
  function automatic logic signed [AXIS_W-1:0] scale_round(
    input logic signed [SC_W-1:0] p
  );
    logic signed [SC_W-1:0] b;
    logic signed [R_W-1:0]  r;
    b = p[SC_W-1] ? (p + SC_W'((1 <<< SCALE_SHIFT) - 1)) : p;
    r = b[SC_W-1:SCALE_SHIFT];
    if (r > R_MAX) begin
      r = R_MAX;
    end else if (r < R_MIN) begin
      r = R_MIN;
    end
    return r[AXIS_W-1:0];
  endfunction

  // History storage and its bookkeeping.
  logic signed [DX_W-1:0] hist_x [DEPTH];
  logic signed [DX_W-1:0] hist_y [DEPTH];
  logic [PTR_W-1:0]       head_r;
  logic [PTR_W-1:0]       head_nxt;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [CMP_W-1:0]       lim;
  logic [CNT_W-1:0]       cnt_clr;
  logic [CNT_W-1:0]       cnt_trim;
  logic [CNT_W-1:0]       cnt_cap;
  logic                   in_moved;
  logic                   push;

  // Weighted sum pipeline.
  logic [CNT_W-1:0]        left_r;
  logic                    v1_r;
  logic                    v2_r;
  logic [PTR_W-1:0]        rptr_r;
  logic signed [DX_W-1:0]  rdx_r;
  logic signed [DX_W-1:0]  rdy_r;
  logic [WGT_W-1:0]        sw_r;
  logic [WGT_W-1:0]        w_eff;
  logic [2*WGT_W-1:0]      sw_full;
  logic signed [PRD_W:0]   mx_full;
  logic signed [PRD_W:0]   my_full;
  logic signed [PRD_W-1:0] prodx_r;
  logic signed [PRD_W-1:0] prody_r;
  logic signed [SUM_W-1:0] accx_r;
  logic signed [SUM_W-1:0] accy_r;

  // Divider.
  logic [DCNT_W-1:0] dcnt_r;
  logic [DIV_W-1:0]  dqx_r;
  logic [DIV_W-1:0]  dqy_r;
  logic [CNT_W-1:0]  remx_r;
  logic [CNT_W-1:0]  remy_r;
  logic              sgnx_r;
  logic              sgny_r;
  logic [DIV_W-1:0]  dqx_a;
  logic [DIV_W-1:0]  dqy_a;
  logic [CNT_W-1:0]  remx_a;
  logic [CNT_W-1:0]  remy_a;
  logic [DIV_W-1:0]  dqx_nxt;
  logic [DIV_W-1:0]  dqy_nxt;
  logic [CNT_W-1:0]  remx_nxt;
  logic [CNT_W-1:0]  remy_nxt;
  logic [SUM_W-1:0]  magx;
  logic [SUM_W-1:0]  magy;
  logic [AVG_W-1:0]  qx;
  logic [AVG_W-1:0]  qy;

  // Scaling and results.
  logic signed [AVG_W-1:0]  avgx_r;
  logic signed [AVG_W-1:0]  avgy_r;
  logic signed [SC_W-1:0]   scx_r;
  logic signed [SC_W-1:0]   scy_r;
  logic signed [AXIS_W-1:0] axx;
  logic signed [AXIS_W-1:0] axy;
  logic signed [AXIS_W-1:0] held_x_r;
  logic signed [AXIS_W-1:0] held_y_r;
  logic                     moved_r;
  logic                     send_r;
  logic                     out_valid_r;
  pmsf_out_t                out_data_r;

  // Trim, clear and push bookkeeping for the incoming beat.
  always_comb begin
    in_moved = (in_data.delta_x != '0) || (in_data.delta_y != '0);
    push     = in_moved && cfg.smoothing_enable;
    lim      = (CMP_W'(cfg.sample_limit) > LIM_MAX) ? LIM_MAX : CMP_W'(cfg.sample_limit);
    cnt_clr  = in_data.clear_history ? '0 : count_r;
    cnt_trim = (CMP_W'(cnt_clr) > lim) ? (cnt_clr - CNT_W'(1)) : cnt_clr;
    cnt_cap  = (cnt_trim > CNT_TOP) ? CNT_TOP : cnt_trim;
    count_nxt = push ? (cnt_cap + CNT_W'(1)) : cnt_trim;
    head_nxt  = (head_r == '0) ? LAST_PTR : (head_r - PTR_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
    end else if (cmd.load) begin
      count_r <= count_nxt;
      if (push) begin
        head_r <= head_nxt;
      end
    end
  end

  // History memory: newest entry sits at the head, older ones follow.
  always_ff @(posedge clk) begin
    if (cmd.load && push) begin
      hist_x[head_nxt] <= in_data.delta_x;
      hist_y[head_nxt] <= in_data.delta_y;
    end
    if (left_r != '0) begin
      rdx_r <= hist_x[rptr_r];
      rdy_r <= hist_y[rptr_r];
    end
  end

  // Walk control: one read issued per cycle, two stages behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else if (cmd.walk_start) begin
      left_r <= count_r;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      v1_r <= (left_r != '0);
      v2_r <= v1_r;
      if (left_r != '0) begin
        left_r <= left_r - CNT_W'(1);
      end
    end
  end

  // Weight products for the entry in the read register.
  always_comb begin
    w_eff   = (cfg.decay_weight > WGT_ONE) ? WGT_ONE : cfg.decay_weight;
    sw_full = sw_r * w_eff;
    mx_full = rdx_r * $signed({1'b0, sw_r});
    my_full = rdy_r * $signed({1'b0, sw_r});
  end

  // Weighted sum: multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      rptr_r <= head_r;
      sw_r   <= WGT_ONE;
      accx_r <= '0;
      accy_r <= '0;
    end else begin
      if (left_r != '0) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : (rptr_r + PTR_W'(1));
      end
      if (v1_r) begin
        prodx_r <= mx_full[PRD_W-1:0];
        prody_r <= my_full[PRD_W-1:0];
        sw_r    <= sw_full[FRAC_SHIFT +: WGT_W];
      end
      if (v2_r) begin
        accx_r <= accx_r + SUM_W'(prodx_r);
        accy_r <= accy_r + SUM_W'(prody_r);
      end
    end
  end

  // Divider: magnitudes in, two quotient bits per cycle.
  always_comb begin
    magx = accx_r[SUM_W-1] ? (SUM_W'(0) - $unsigned(accx_r)) : $unsigned(accx_r);
    magy = accy_r[SUM_W-1] ? (SUM_W'(0) - $unsigned(accy_r)) : $unsigned(accy_r);
    {remx_a, dqx_a}     = div_step(remx_r, dqx_r, count_r);
    {remx_nxt, dqx_nxt} = div_step(remx_a, dqx_a, count_r);
    {remy_a, dqy_a}     = div_step(remy_r, dqy_r, count_r);
    {remy_nxt, dqy_nxt} = div_step(remy_a, dqy_a, count_r);
    qx = dqx_r[AVG_W-1:0];
    qy = dqy_r[AVG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cmd.div_step && (dcnt_r != '0)) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dqx_r  <= DIV_W'(magx);
      dqy_r  <= DIV_W'(magy);
      remx_r <= '0;
      remy_r <= '0;
      sgnx_r <= accx_r[SUM_W-1];
      sgny_r <= accy_r[SUM_W-1];
    end else if (cmd.div_step && (dcnt_r != '0)) begin
      dqx_r  <= dqx_nxt;
      dqy_r  <= dqy_nxt;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
    end
  end

  // Average: pass-through value on load, signed quotient after division.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      avgx_r <= {in_data.delta_x, {FRAC_SHIFT{1'b0}}};
      avgy_r <= {in_data.delta_y, {FRAC_SHIFT{1'b0}}};
    end else if (cmd.avg_load) begin
      avgx_r <= sgnx_r ? (AVG_W'(0) - qx) : qx;
      avgy_r <= sgny_r ? (AVG_W'(0) - qy) : qy;
    end
  end

  // Gain multiply, registered before rounding.
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scx_r <= avgx_r * $signed({1'b0, cfg.yaw_gain});
      scy_r <= avgy_r * $signed({1'b0, cfg.pitch_gain});
    end
  end

  always_comb begin
    axx = scale_round(scx_r);
    axy = scale_round(scy_r);
  end

  // Held axes carry over beats without motion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (cmd.round) begin
      held_x_r <= axx;
      held_y_r <= axy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      moved_r <= in_moved;
      send_r  <= 1'b0;
    end else if (cmd.round) begin
      send_r <= (axx != '0) || (axy != '0);
    end
  end

  // Result register: loaded only when empty or draining this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.moved      <= moved_r;
      out_data_r.send_event <= send_r;
      out_data_r.axis_x     <= held_x_r;
      out_data_r.axis_y     <= held_y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  always_comb begin
    st.in_moved  = in_moved;
    st.smooth    = cfg.smoothing_enable;
    st.walk_done = (left_r == '0) && !v1_r && !v2_r;
    st.div_done  = (dcnt_r == '0);
    st.out_free  = !out_valid_r || !out_stall;
  end

endmodule

// ===== rtl/pointer_motion_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// pointer_motion_smoothing_filter: geometric weighted pointer smoothing
// Averages pointer displacements over a trimmed history with geometric
// weights, scales both axes by their gains and flags motion events.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    pmsf_in_t  (delta_x, delta_y, clear)
//   out_     output     out_valid / out_stall  pmsf_out_t (moved, event, axes)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A smoothed beat walks count history entries, where count is the history length
// after the push (up to 65 entries): the walk reads one entry per cycle and the
// divider resolves two quotient bits per cycle. Pass-through beats skip the walk
// and division, beats without motion go straight to the result register; the next
// beat is taken once the result is loaded. A stalled result waits in the output
// register and holds back the next result. Reset is synchronous and empties the history.
// ----------------------------------------------------------------------------
module pointer_motion_smoothing_filter
  import pmsf_pkg::*;
#(
  parameter int MAX_SAMPLE_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pmsf_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pmsf_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pmsf_cfg_t  cfg;
  pmsf_cmd_t  cmd;
  pmsf_stat_t st;

  // Register file.
  pmsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  pmsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  pmsf_dp #(
    .MAX_SAMPLE_LIMIT (MAX_SAMPLE_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted beat keeps the input side closed in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous beat still in work");

  // A motion event always carries a nonzero axis.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.send_event) |->
      ((out_data.axis_x != '0) || (out_data.axis_y != '0)))
    else $error("event flagged with both axes zero");

  // No event without motion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.moved) |-> !out_data.send_event)
    else $error("event flagged on a beat without motion");
`endif

endmodule

// ===== verif/pointer_motion_smoothing_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_motion_smoothing_filter_checker: result checker for the smoother
// Watches the input, result and register channels of the block. It keeps its
// own copy of the history window, gains and held axes, predicts the result of
// every accepted input beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module pointer_motion_smoothing_filter_checker
  import pmsf_pkg::*;
#(
  parameter int MAX_SAMPLE_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  pmsf_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  pmsf_out_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    fail_total,
  output int                    checked_total
);

  localparam int     DEPTH   = MAX_SAMPLE_LIMIT + 1;
  localparam longint AXIS_HI = (64'sd1 <<< (AXIS_W - 1)) - 1;
  localparam longint AXIS_LO = -(64'sd1 <<< (AXIS_W - 1));

  // Predicted register contents.
  logic              smooth_on;
  logic [WGT_W-1:0]  weight_q16;
  logic [LIM_W-1:0]  limit_reg;
  logic [GAIN_W-1:0] yaw_q12;
  logic [GAIN_W-1:0] pitch_q12;

  // Predicted history window, index 0 newest, and the held axes.
  logic signed [DX_W-1:0]   hist_dx [DEPTH];
  logic signed [DX_W-1:0]   hist_dy [DEPTH];
  int unsigned              hist_len;
  logic signed [AXIS_W-1:0] held_x;
  logic signed [AXIS_W-1:0] held_y;

  pmsf_out_t expected_motion [$];
  int        bad_beats;
  int        beats_checked;

  // Gain scaling: Q.16 average times Q4.12 gain, back to 8 fraction bits,
  // truncated toward zero and clipped to the axis range.
  function automatic logic signed [AXIS_W-1:0] apply_gain(longint avg, logic [GAIN_W-1:0] gain);
    longint r;
    r = (avg * longint'(gain)) / 64'sd1048576;
    if (r > AXIS_HI) r = AXIS_HI;
    if (r < AXIS_LO) r = AXIS_LO;
    return r[AXIS_W-1:0];
  endfunction

  // One frame tick: clear, trim, push and average, then scale and hold.
  task automatic predict_motion(input pmsf_in_t beat, output pmsf_out_t res);
    int unsigned       lim;
    int unsigned       w;
    int unsigned       i;
    longint unsigned   run_w;
    longint            sum_x;
    longint            sum_y;
    longint            avg_x;
    longint            avg_y;
    lim = (limit_reg > MAX_SAMPLE_LIMIT) ? MAX_SAMPLE_LIMIT : limit_reg;
    res = '0;
    if (beat.clear_history) hist_len = 0;
    // At most one entry leaves per tick, moving or not.
    if (hist_len > lim) hist_len--;
    if (beat.delta_x != 0 || beat.delta_y != 0) begin
      res.moved = 1'b1;
      if (smooth_on) begin
        w = (weight_q16 > WGT_ONE) ? WGT_ONE : weight_q16;
        if (hist_len > DEPTH - 1) hist_len = DEPTH - 1;
        for (i = hist_len; i > 0; i--) begin
          hist_dx[i] = hist_dx[i-1];
          hist_dy[i] = hist_dy[i-1];
        end
        hist_dx[0] = beat.delta_x;
        hist_dy[0] = beat.delta_y;
        hist_len++;
        // Geometric weights from the newest entry, each truncated in Q1.16.
        run_w = 65536;
        sum_x = 0;
        sum_y = 0;
        for (i = 0; i < hist_len; i++) begin
          sum_x += longint'(hist_dx[i]) * longint'(run_w);
          sum_y += longint'(hist_dy[i]) * longint'(run_w);
          run_w = (run_w * w) >> 16;
        end
        avg_x = sum_x / longint'(hist_len);
        avg_y = sum_y / longint'(hist_len);
      end else begin
        avg_x = longint'($signed(beat.delta_x)) * 65536;
        avg_y = longint'($signed(beat.delta_y)) * 65536;
      end
      held_x = apply_gain(avg_x, yaw_q12);
      held_y = apply_gain(avg_y, pitch_q12);
      res.send_event = (held_x != 0) || (held_y != 0);
    end
    res.axis_x = held_x;
    res.axis_y = held_y;
  endtask

  task automatic show_field(string name, logic signed [AXIS_W-1:0] want,
                            logic signed [AXIS_W-1:0] got);
    $display("%0t: beat %0d %s expected %0d, actual %0d", $time, beats_checked, name, want, got);
  endtask

  // Channel monitor. Results are taken before inputs so that a result and
  // a new input on the same edge never pair up with each other.
  always @(posedge clk) begin
    pmsf_out_t want_beat;
    if (!rst_n) begin
      smooth_on  = RST_SMOOTH;
      weight_q16 = RST_WEIGHT;
      limit_reg  = RST_LIMIT;
      yaw_q12    = RST_YAW;
      pitch_q12  = RST_PITCH;
      hist_len   = 0;
      held_x     = '0;
      held_y     = '0;
      expected_motion.delete();
      bad_beats     = 0;
      beats_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_motion.size() == 0) begin
          bad_beats++;
          $display("%0t: result beat with nothing expected: moved %0d event %0d x %0d y %0d",
                   $time, out_data.moved, out_data.send_event, out_data.axis_x,
                   out_data.axis_y);
        end else begin
          want_beat = expected_motion.pop_front();
          if (out_data !== want_beat) begin
            bad_beats++;
            if (out_data.moved !== want_beat.moved)
              show_field("moved", want_beat.moved, out_data.moved);
            if (out_data.send_event !== want_beat.send_event)
              show_field("send_event", want_beat.send_event, out_data.send_event);
            if (out_data.axis_x !== want_beat.axis_x)
              show_field("axis_x", want_beat.axis_x, out_data.axis_x);
            if (out_data.axis_y !== want_beat.axis_y)
              show_field("axis_y", want_beat.axis_y, out_data.axis_y);
          end
          beats_checked++;
        end
      end
      // Register writes; an unmapped index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SMOOTH: smooth_on  = cfg_data[0];
          REG_WEIGHT: weight_q16 = cfg_data[WGT_W-1:0];
          REG_LIMIT:  limit_reg  = cfg_data[LIM_W-1:0];
          REG_YAW:    yaw_q12    = cfg_data[GAIN_W-1:0];
          REG_PITCH:  pitch_q12  = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_motion(in_data, want_beat);
        expected_motion.insert(expected_motion.size(), want_beat);
      end
    end
    outstanding   <= expected_motion.size();
    fail_total    <= bad_beats;
    checked_total <= beats_checked;
  end

endmodule

// ===== verif/pointer_motion_smoothing_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_motion_smoothing_filter_test: regression top for the smoother
// Drives pointer displacement beats through a series of register settings,
// from the reset values to the extremes and random ones, with random gaps on
// both channels in the first six phases. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module pointer_motion_smoothing_filter_test;
  import pmsf_pkg::*;

  localparam int MAX_SAMPLE_LIMIT = 64;
  localparam int PHASES           = 9;
  localparam int BEATS_PER_PHASE  = 120;
  localparam int SETTLE_CYCLES    = 120;
  localparam int STALL_LIMIT      = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pmsf_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pmsf_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int beats_sent         = 0;
  int quiet_cycles;
  int outstanding;
  int fail_total;
  int checked_total;

  pointer_motion_smoothing_filter #(
    .MAX_SAMPLE_LIMIT(MAX_SAMPLE_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pointer_motion_smoothing_filter_checker #(
    .MAX_SAMPLE_LIMIT(MAX_SAMPLE_LIMIT)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .fail_total   (fail_total),
    .checked_total(checked_total)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, independent of out_valid.
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: ends the run when no beat has moved on any channel too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no beat accepted for %0d cycles.", STALL_LIMIT);
    $display("pointer_motion_smoothing_filter regression: fail");
    $finish;
  end

  // Offers one input beat after a random gap and waits until it is taken.
  task automatic send_motion(input logic signed [DX_W-1:0] dx, dy, input logic clear);
    pmsf_in_t beat;
    beat.delta_x       = dx;
    beat.delta_y       = dy;
    beat.clear_history = clear;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Displacement mix: zero, the extremes, small steps and full range.
  function automatic logic signed [DX_W-1:0] pick_delta();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      3, 4, 5: return DX_W'($urandom_range(8) - 4);
      default: return DX_W'($urandom());
    endcase
  endfunction

  task automatic send_random_beat();
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    if ($urandom_range(9) == 0) begin
      dx = '0;
      dy = '0;
    end else begin
      dx = pick_delta();
      dy = pick_delta();
    end
    send_motion(dx, dy, $urandom_range(49) == 0);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Register settings per phase: pass through, zero weight and limit, full
  // weight, values above range, tiny gains, a short limit, and random ones.
  task automatic apply_setting(input int phase);
    case (phase)
      1: begin
        write_reg(REG_SMOOTH, 0);
        write_reg(REG_WEIGHT, 66);
        write_reg(REG_LIMIT, 2);
        write_reg(REG_YAW, 41);
        write_reg(REG_PITCH, 40960);
      end
      2: begin
        write_reg(REG_SMOOTH, 1);
        write_reg(REG_WEIGHT, 0);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_YAW, 40960);
        write_reg(REG_PITCH, 41);
      end
      3: begin
        write_reg(REG_WEIGHT, 65536);
        write_reg(REG_LIMIT, 64);
        write_reg(REG_YAW, 4096);
        write_reg(REG_PITCH, 4096);
      end
      4: begin
        write_reg(REG_WEIGHT, 131071);
        write_reg(REG_LIMIT, 127);
        write_reg(REG_YAW, 65535);
        write_reg(REG_PITCH, 0);
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(131071)));
      end
      5: begin
        write_reg(REG_WEIGHT, 41);
        write_reg(REG_LIMIT, 64);
        write_reg(REG_YAW, 41);
        write_reg(REG_PITCH, 41);
      end
      6: begin
        // A short limit after a long history: the window shrinks one per tick.
        write_reg(REG_WEIGHT, 39322);
        write_reg(REG_LIMIT, 3);
        write_reg(REG_YAW, 20000);
        write_reg(REG_PITCH, 8000);
      end
      default: begin
        write_reg(REG_SMOOTH, CFG_DATA_W'($urandom_range(1)));
        write_reg(REG_WEIGHT, CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(131071)
                                                        : $urandom_range(65536, 66)));
        write_reg(REG_LIMIT, CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                       : $urandom_range(64, 2)));
        write_reg(REG_YAW, CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                     : $urandom_range(40960, 41)));
        write_reg(REG_PITCH, CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(40960, 41)));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // The sender holds off until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      // Gap pattern: receiver-heavy, then sender-heavy, then none.
      case (phase / 3)
        0: begin
          sender_idle_pct    = 36;
          receiver_stall_pct = 59;
        end
        1: begin
          sender_idle_pct    = 59;
          receiver_stall_pct = 36;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      if (phase > 0) apply_setting(phase);
      if (phase == 0) begin
        // Opening beats at the reset settings: held zero, extremes, clears.
        send_motion('0, '0, 1'b0);
        send_motion(16'sd1, '0, 1'b0);
        send_motion('0, -16'sd1, 1'b0);
        send_motion(16'sh7FFF, 16'sh8000, 1'b0);
        send_motion(16'sh8000, 16'sh7FFF, 1'b0);
        send_motion('0, '0, 1'b0);
        send_motion('0, '0, 1'b1);
        send_motion(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_motion(16'sh8000, 16'sh8000, 1'b0);
        send_motion(-16'sd1, -16'sd1, 1'b0);
        send_motion(16'sd2, -16'sd2, 1'b0);
        send_motion('0, '0, 1'b0);
        send_motion(16'sh8000, '0, 1'b1);
        send_motion('0, 16'sh7FFF, 1'b0);
      end
      repeat (BEATS_PER_PHASE) send_random_beat();
      drain_results();
    end

    $display("Checked %0d results for %0d input beats over %0d register settings,",
             checked_total, beats_sent, PHASES);
    $display("with smoothing on and off, weights and limits past both ends, and clears.");
    if (fail_total == 0)
      $display("pointer_motion_smoothing_filter regression: pass");
    else
      $display("pointer_motion_smoothing_filter regression: fail");
    $finish;
  end

endmodule
